[rtl/wsfd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the websocket frame deframer.
// No dependencies; imported by every module of the block.
package wsfd_pkg;

  // Event codes on the result stream
  localparam logic [1:0] EV_BYTE  = 2'd0;  // payload byte
  localparam logic [1:0] EV_EMPTY = 2'd1;  // empty text/binary frame
  localparam logic [1:0] EV_PONG  = 2'd2;  // ping seen, pong requested
  localparam logic [1:0] EV_BAD   = 2'd3;  // invalid opcode

  // Opcodes of interest
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_BIN   = 4'h2;
  localparam logic [3:0] OPC_CTL_LO_MAX = 4'h3;  // last valid data-range opcode
  localparam logic [3:0] OPC_CTL_LO     = 4'h8;  // first control opcode
  localparam logic [3:0] OPC_PING  = 4'h9;
  localparam logic [3:0] OPC_CTL_HI_MAX = 4'hB;  // last valid control opcode

  // Header byte fields
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // Stream widths
  localparam int unsigned RX_TDATA_W = 8;
  localparam int unsigned TX_TDATA_W = 80;  // 76 bits of fields, padded to bytes
  localparam int unsigned TX_TUSER_W = 3;

  // One result item
  typedef struct packed {
    logic [3:0]  bad_opcode;
    logic [63:0] payload_length;
    logic        last_byte;
    logic [7:0]  payload_byte;
    logic        frame_kind;
    logic [1:0]  event_res;
  } result_t;

  // Write port of the mask key memory
  typedef struct packed {
    logic       we;
    logic [1:0] addr;
    logic [7:0] data;
  } key_wr_t;

  // Opcodes 4..7 and 12..15 are reserved
  function automatic logic opcode_bad(input logic [3:0] opc);
    return ((opc > OPC_CTL_LO_MAX) && (opc < OPC_CTL_LO)) || (opc > OPC_CTL_HI_MAX);
  endfunction

  function automatic logic opcode_data(input logic [3:0] opc);
    return (opc == OPC_TEXT) || (opc == OPC_BIN);
  endfunction

endpackage

[rtl/wsfd_key_mem.sv]
`timescale 1ns / 1ps
// Mask key memory: 4 x 8 bits, one write port, one registered read port.
// Depends on wsfd_pkg for the write port struct.
module wsfd_key_mem (
  input  logic            clk_i,
  input  wsfd_pkg::key_wr_t wr_i,
  input  logic [1:0]      raddr_i,
  output logic [7:0]      rdata_o
);
  import wsfd_pkg::*;

  logic [7:0] mem [4];
  logic [7:0] rdata_q;

  // Read-before-write; the parser never reads the entry it writes
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/wsfd_parser.sv]
`timescale 1ns / 1ps
// Frame header parser and payload unmasker, one byte per accepted item.
// Depends on wsfd_pkg; mask key bytes live in wsfd_key_mem.
module wsfd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                buffer_start_i,
  input  logic [7:0]          key_rdata_i,
  output wsfd_pkg::key_wr_t   key_wr_o,
  output logic [1:0]          key_raddr_o,
  output logic                res_valid_o,
  output wsfd_pkg::result_t   res_o
);
  import wsfd_pkg::*;

  localparam logic [2:0] PH_OPCODE = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_EXT    = 3'd2;
  localparam logic [2:0] PH_MASK   = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [63:0] flen_q, flen_d;
  logic [1:0]  kidx_q, kidx_d;
  logic [63:0] left_q, left_d;
  logic        discard_q, discard_d;

  // Next-state and result logic
  always_comb begin
    logic [2:0]  ph;
    logic        disc;
    logic        hdr_done;
    logic        hdr_key_read;
    logic [7:0]  keyb;
    logic [7:0]  ob;

    phase_d     = phase_q;
    opcode_d    = opcode_q;
    masked_d    = masked_q;
    ext_left_d  = ext_left_q;
    flen_d      = flen_q;
    kidx_d      = kidx_q;
    left_d      = left_q;
    discard_d   = discard_q;
    key_wr_o    = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    hdr_done     = 1'b0;
    hdr_key_read = 1'b0;
    keyb         = 8'h00;
    ob           = 8'h00;
    ph           = buffer_start_i ? PH_OPCODE : phase_q;
    disc         = buffer_start_i ? 1'b0 : discard_q;

    if (accept_i) begin
      phase_d   = ph;
      discard_d = disc;
      if (!disc) begin
        case (ph)
          PH_LEN: begin
            masked_d = rx_byte_i[7];
            if ((rx_byte_i[6:0] == LEN7_EXT16) || (rx_byte_i[6:0] == LEN7_EXT64)) begin
              flen_d     = '0;
              ext_left_d = (rx_byte_i[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
              phase_d    = PH_EXT;
            end else begin
              flen_d   = {57'd0, rx_byte_i[6:0]};
              hdr_done = 1'b1;
            end
          end
          PH_EXT: begin
            flen_d     = {flen_q[55:0], rx_byte_i};
            ext_left_d = ext_left_q - 4'd1;
            hdr_done   = (ext_left_d == 4'd0);
          end
          PH_MASK: begin
            key_wr_o.we   = 1'b1;
            key_wr_o.addr = kidx_q;
            key_wr_o.data = rx_byte_i;
            kidx_d        = kidx_q + 2'd1;
            hdr_done      = (kidx_d == 2'd0);
            hdr_key_read  = 1'b1;
          end
          PH_DATA: begin
            keyb   = masked_q ? key_rdata_i : 8'h00;
            ob     = rx_byte_i ^ keyb;
            kidx_d = kidx_q + 2'd1;
            left_d = left_q - 64'd1;
            if (left_q == 64'd1) begin
              phase_d = PH_OPCODE;
            end
            if (opcode_data(opcode_q)) begin
              res_valid_o          = 1'b1;
              res_o.event_res      = EV_BYTE;
              res_o.frame_kind     = (opcode_q == OPC_BIN);
              res_o.payload_byte   = ob;
              res_o.last_byte      = (left_q == 64'd1);
              res_o.payload_length = flen_q;
            end
          end
          default: begin
            opcode_d = rx_byte_i[3:0];
            if (opcode_bad(rx_byte_i[3:0])) begin
              discard_d            = 1'b1;
              phase_d              = PH_OPCODE;
              res_valid_o          = 1'b1;
              res_o.event_res      = EV_BAD;
              res_o.bad_opcode     = rx_byte_i[3:0];
            end else begin
              phase_d = PH_LEN;
              if (rx_byte_i[3:0] == OPC_PING) begin
                res_valid_o     = 1'b1;
                res_o.event_res = EV_PONG;
              end
            end
          end
        endcase

        // End of header: fetch the key, finish an empty frame, or start payload
        if (hdr_done) begin
          kidx_d = 2'd0;
          if (masked_d && !hdr_key_read) begin
            phase_d = PH_MASK;
          end else if (flen_d == 64'd0) begin
            phase_d = PH_OPCODE;
            if (opcode_data(opcode_q)) begin
              res_valid_o      = 1'b1;
              res_o.event_res  = EV_EMPTY;
              res_o.frame_kind = (opcode_q == OPC_BIN);
              res_o.last_byte  = 1'b1;
            end
          end else begin
            phase_d = PH_DATA;
            left_d  = flen_d;
          end
        end
      end
    end
  end

  // Prefetch the key byte for the next payload byte
  assign key_raddr_o = kidx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_OPCODE;
      opcode_q   <= '0;
      masked_q   <= 1'b0;
      ext_left_q <= '0;
      flen_q     <= '0;
      kidx_q     <= '0;
      left_q     <= '0;
      discard_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      masked_q   <= masked_d;
      ext_left_q <= ext_left_d;
      flen_q     <= flen_d;
      kidx_q     <= kidx_d;
      left_q     <= left_d;
      discard_q  <= discard_d;
    end
  end

  // Discard mode stays silent until a new buffer starts
  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && discard_q && !buffer_start_i |-> !res_valid_o)
    else $error("result produced while discarding");

  // A bad opcode always enters discard mode
  a_bad_discards: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_valid_o && (res_o.event_res == EV_BAD) |=> discard_q)
    else $error("bad opcode did not set discard");

  // Last payload byte returns to header parsing
  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_valid_o && (res_o.event_res == EV_BYTE) && res_o.last_byte
    |=> phase_q == PH_OPCODE)
    else $error("frame did not end after last byte");

endmodule

[rtl/wsfd_out_buf.sv]
`timescale 1ns / 1ps
// Output register with one skid stage for the result stream.
// Depends on wsfd_pkg for the result struct.
module wsfd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  wsfd_pkg::result_t res_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output wsfd_pkg::result_t out_o,
  input  logic              out_ready_i
);
  import wsfd_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  // Upstream may send while the skid slot is free
  assign in_ready_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = skid_valid_q;
      out_d       = skid_q;
      skid_valid_d = 1'b0;
    end
    if (res_valid_i) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_d = 1'b1;
        out_d       = res_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The skid slot is only used behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item with the output empty");

  // A taken output with a parked item moves it forward
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_ready_i |=> out_valid_q && !skid_valid_q)
    else $error("skid item not moved forward");

  // No result arrives while the skid slot is full
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !res_valid_i)
    else $error("result lost on full buffer");

endmodule

[rtl/websocket_frame_deframer.sv]
`timescale 1ns / 1ps
// Websocket frame deframer: one received byte per cycle in, one result per cycle out,
// both while m_axis is taken. A result is registered in the output register, or in the
// skid slot while the output is held. One byte every clock; the parser state updates per
// byte; the mask key memory is read a byte ahead. Input stalls only when two results wait.
// Reset clears the parser and output control state; the 4-byte key memory is not
// cleared, as every masked frame writes its key before any payload byte reads it.
module websocket_frame_deframer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [wsfd_pkg::RX_TDATA_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
  input  logic                               s_axis_tuser,   // [0] buffer_start
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [wsfd_pkg::TX_TDATA_W-1:0]    m_axis_tdata,   // [7:0] payload_byte,
                                                             // [71:8] payload_length,
                                                             // [75:72] bad_opcode, [79:76] 0
  output logic [wsfd_pkg::TX_TUSER_W-1:0]    m_axis_tuser,   // [1:0] event_res,
                                                             // [2] frame_kind
  output logic                               m_axis_tlast    // last_byte
);
  import wsfd_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  key_wr_t key_wr;
  logic [1:0] key_raddr;
  logic [7:0] key_rdata;

  assign accept = s_axis_tvalid && s_axis_tready;

  wsfd_key_mem u_key_mem (
    .clk_i   (clk_i),
    .wr_i    (key_wr),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  wsfd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .rx_byte_i      (s_axis_tdata),
    .buffer_start_i (s_axis_tuser),
    .key_rdata_i    (key_rdata),
    .key_wr_o       (key_wr),
    .key_raddr_o    (key_raddr),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  wsfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (out_res),
    .out_ready_i (m_axis_tready)
  );

  // Pack the result item onto the stream
  assign m_axis_tdata = {4'd0, out_res.bad_opcode, out_res.payload_length,
                         out_res.payload_byte};
  assign m_axis_tuser = {out_res.frame_kind, out_res.event_res};
  assign m_axis_tlast = out_res.last_byte;

endmodule
